@@ design/heading_pid_thruster_mixer_assert.svh @@
// Assertion macros shared by the RTL files.
`ifndef HEADING_PID_THRUSTER_MIXER_ASSERT_SVH
`define HEADING_PID_THRUSTER_MIXER_ASSERT_SVH

`ifndef SYNTH
`define HPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HPM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/hpm_pkg.sv @@
`default_nettype none

package hpm_pkg;

   localparam int YAW_W      = 15;
   localparam int GAIN_W     = 16;
   localparam int STICK_W    = 10;
   localparam int PULSE_W    = 12;
   localparam int CORR_W     = 10;
   localparam int ERR_W      = 16;
   localparam int CSR_DATA_W = 16;

   localparam int HALF_TURN  = 11520;
   localparam int FULL_TURN  = 23040;
   localparam int OUT_LIMIT  = 400;
   localparam int NEUTRAL    = 1500;
   localparam int BASE_HIGH  = 1800;
   localparam int BASE_LOW   = 1200;
   localparam int STICK_FULL = 500;
   localparam int SPIN_LOW   = 1000;
   localparam int SPIN_HIGH  = 2000;
   localparam int KI_SCALE   = 100;

   localparam logic signed [STICK_W-1:0] STICK_POS = STICK_W'(STICK_FULL);
   localparam logic signed [STICK_W-1:0] STICK_NEG = STICK_W'(-STICK_FULL);

   typedef enum logic [1:0] {
      CSR_TARGET,
      CSR_PROP,
      CSR_INTEG,
      CSR_DERIV
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_TRANSLATE,
      MODE_SPIN_LEFT,
      MODE_SPIN_RIGHT
   } mode_type;

   typedef enum logic [2:0] {
      DIR_FWD,
      DIR_BACK,
      DIR_LEFT,
      DIR_RIGHT,
      DIR_HOLD
   } dir_type;

   typedef enum logic [1:0] {
      MIX_NEUTRAL,
      MIX_SPIN_LEFT,
      MIX_SPIN_RIGHT,
      MIX_PID
   } mix_type;

   typedef struct packed {
      mix_type mix;
      dir_type dir;
   } ctrl_type;

   typedef struct packed {
      logic signed [YAW_W-1:0]  target;
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
   } cfg_type;

endpackage

`default_nettype wire

@@ design/heading_pid_thruster_mixer.sv @@
// Heading-hold PID controller with a four-thruster mixer.
// Configuration: csr_valid/csr_ready with csr_index and csr_data write the
// target heading and the three gains; csr_ready is always high. Write only
// while no request is in flight.
// Requests: one control tick per req transfer (yaw, stick, switches, enable).
// Responses: one rsp transfer per request, in order, carrying the four
// thruster pulse widths and the applied correction.
// Pipeline: error/integral update, gain multiplies, sum, then divide/clamp/mix
// into the output register, each in its own registered stage.
// Throughput: one request per cycle unless rsp stalls. The heading error,
// wrap and saturating integral update close their loop in the front stage.
// Each stage has its own valid; when the receiver stalls, rsp holds and the
// stages behind it fill, then req_ready drops.
// Reset clears the gains, target, drive mode, last error, integral and all
// stage valids.
`default_nettype none

module heading_pid_thruster_mixer #(
   parameter int GAIN_FRAC_BITS = 8,
   parameter int INTEG_WIDTH    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  hpm_pkg::csr_index_type              csr_index,
   input  logic [hpm_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hpm_pkg::YAW_W-1:0]    req_yaw,
   input  logic signed [hpm_pkg::STICK_W-1:0]  req_stick_x,
   input  logic signed [hpm_pkg::STICK_W-1:0]  req_stick_y,
   input  logic                                req_left_switch,
   input  logic                                req_right_switch,
   input  logic                                req_motors_enabled,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hpm_pkg::PULSE_W-1:0]         rsp_thruster_a,
   output logic [hpm_pkg::PULSE_W-1:0]         rsp_thruster_b,
   output logic [hpm_pkg::PULSE_W-1:0]         rsp_thruster_c,
   output logic [hpm_pkg::PULSE_W-1:0]         rsp_thruster_d,
   output logic signed [hpm_pkg::CORR_W-1:0]   rsp_correction
);
   import hpm_pkg::*;

   localparam int PD_W  = GAIN_W + ERR_W;
   localparam int I_W   = GAIN_W + INTEG_WIDTH;
   localparam int ACC_W = GAIN_W + INTEG_WIDTH + 2;

   cfg_type cfg_ff, cfg_in;

   logic                          f_valid, f_ready;
   ctrl_type                      f_ctrl;
   logic signed [ERR_W-1:0]       f_err;
   logic signed [ERR_W-1:0]       f_delta;
   logic signed [INTEG_WIDTH-1:0] f_sum;

   logic                          m_valid, m_ready;
   ctrl_type                      m_ctrl;
   logic signed [PD_W-1:0]        m_p;
   logic signed [I_W-1:0]         m_i;
   logic signed [PD_W-1:0]        m_d;

   logic                          s_valid, s_ready;
   ctrl_type                      s_ctrl;
   logic signed [ACC_W-1:0]       s_acc;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET: cfg_in.target = csr_data[YAW_W-1:0];
            CSR_PROP:   cfg_in.kp     = csr_data[GAIN_W-1:0];
            CSR_INTEG:  cfg_in.ki     = csr_data[GAIN_W-1:0];
            CSR_DERIV:  cfg_in.kd     = csr_data[GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpm_front #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .INTEG_WIDTH    (INTEG_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .yaw            (req_yaw),
      .stick_x        (req_stick_x),
      .stick_y        (req_stick_y),
      .left_switch    (req_left_switch),
      .right_switch   (req_right_switch),
      .motors_enabled (req_motors_enabled),
      .out_valid      (f_valid),
      .out_ready      (f_ready),
      .out_ctrl       (f_ctrl),
      .out_err        (f_err),
      .out_delta      (f_delta),
      .out_sum        (f_sum)
   );

   hpm_mult #(
      .INTEG_WIDTH (INTEG_WIDTH)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_ctrl   (f_ctrl),
      .in_err    (f_err),
      .in_delta  (f_delta),
      .in_sum    (f_sum),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_ctrl  (m_ctrl),
      .out_p     (m_p),
      .out_i     (m_i),
      .out_d     (m_d)
   );

   hpm_acc #(
      .INTEG_WIDTH (INTEG_WIDTH)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_ctrl   (m_ctrl),
      .in_p      (m_p),
      .in_i      (m_i),
      .in_d      (m_d),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_ctrl  (s_ctrl),
      .out_acc   (s_acc)
   );

   hpm_mix #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .INTEG_WIDTH    (INTEG_WIDTH)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_ctrl   (s_ctrl),
      .in_acc    (s_acc),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_a     (rsp_thruster_a),
      .out_b     (rsp_thruster_b),
      .out_c     (rsp_thruster_c),
      .out_d     (rsp_thruster_d),
      .out_corr  (rsp_correction)
   );

endmodule

`default_nettype wire

@@ design/hpm_front.sv @@
`default_nettype none
`include "heading_pid_thruster_mixer_assert.svh"

module hpm_front #(
   parameter int GAIN_FRAC_BITS = 8,
   parameter int INTEG_WIDTH    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hpm_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [hpm_pkg::YAW_W-1:0]    yaw,
   input  logic signed [hpm_pkg::STICK_W-1:0]  stick_x,
   input  logic signed [hpm_pkg::STICK_W-1:0]  stick_y,
   input  logic                                left_switch,
   input  logic                                right_switch,
   input  logic                                motors_enabled,
   output logic                                out_valid,
   input  logic                                out_ready,
   output hpm_pkg::ctrl_type                   out_ctrl,
   output logic signed [hpm_pkg::ERR_W-1:0]    out_err,
   output logic signed [hpm_pkg::ERR_W-1:0]    out_delta,
   output logic signed [INTEG_WIDTH-1:0]       out_sum
);
   import hpm_pkg::*;

   localparam logic signed [INTEG_WIDTH-1:0] SUM_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam logic signed [INTEG_WIDTH-1:0] SUM_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
   localparam int KI_MIN = (1 << GAIN_FRAC_BITS) / KI_SCALE;

   logic                          in_fire;
   logic signed [ERR_W:0]         diff;
   logic signed [ERR_W-1:0]       err;
   logic signed [GAIN_W:0]        ki_ext;
   logic [GAIN_W:0]               ki_mag;
   logic                          ki_active;
   logic signed [INTEG_WIDTH:0]   sum_wide;
   logic signed [INTEG_WIDTH-1:0] sum_sat;
   mode_type                      mode_sel;
   ctrl_type                      ctrl_sel;

   mode_type                      mode_ff, mode_in;
   logic signed [ERR_W-1:0]       last_error_ff, last_error_in;
   logic signed [INTEG_WIDTH-1:0] error_sum_ff, error_sum_in;
   logic                          valid_ff, valid_in;
   ctrl_type                      ctrl_ff;
   logic signed [ERR_W-1:0]       err_ff;
   logic signed [ERR_W-1:0]       delta_ff;
   logic signed [INTEG_WIDTH-1:0] sum_ff;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      diff = (ERR_W+1)'(cfg.target) - (ERR_W+1)'(yaw);
      if (diff > (ERR_W+1)'(HALF_TURN)) begin
         err = ERR_W'(diff - (ERR_W+1)'(FULL_TURN));
      end else if (diff < -(ERR_W+1)'(HALF_TURN)) begin
         err = ERR_W'(diff + (ERR_W+1)'(FULL_TURN));
      end else begin
         err = ERR_W'(diff);
      end

      ki_ext    = (GAIN_W+1)'(cfg.ki);
      ki_mag    = ki_ext[GAIN_W] ? (GAIN_W+1)'(-ki_ext) : (GAIN_W+1)'(ki_ext);
      ki_active = ki_mag > (GAIN_W+1)'(KI_MIN);

      sum_wide = (INTEG_WIDTH+1)'(error_sum_ff) + (INTEG_WIDTH+1)'(err);
      if (sum_wide > (INTEG_WIDTH+1)'(SUM_MAX)) begin
         sum_sat = SUM_MAX;
      end else if (sum_wide < (INTEG_WIDTH+1)'(SUM_MIN)) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = INTEG_WIDTH'(sum_wide);
      end

      if (!left_switch && !right_switch) begin
         mode_sel = MODE_TRANSLATE;
      end else if (left_switch && !right_switch) begin
         mode_sel = MODE_SPIN_LEFT;
      end else if (!left_switch && right_switch) begin
         mode_sel = MODE_SPIN_RIGHT;
      end else begin
         mode_sel = mode_ff;
      end

      if (!motors_enabled) begin
         ctrl_sel.mix = MIX_NEUTRAL;
      end else begin
         case (mode_sel)
            MODE_TRANSLATE: ctrl_sel.mix = MIX_PID;
            MODE_SPIN_LEFT: ctrl_sel.mix = MIX_SPIN_LEFT;
            default:        ctrl_sel.mix = MIX_SPIN_RIGHT;
         endcase
      end

      if (stick_y == STICK_POS) begin
         ctrl_sel.dir = DIR_FWD;
      end else if (stick_y == STICK_NEG) begin
         ctrl_sel.dir = DIR_BACK;
      end else if (stick_x == STICK_NEG) begin
         ctrl_sel.dir = DIR_LEFT;
      end else if (stick_x == STICK_POS) begin
         ctrl_sel.dir = DIR_RIGHT;
      end else begin
         ctrl_sel.dir = DIR_HOLD;
      end

      mode_in       = mode_ff;
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      if (in_fire) begin
         if (!motors_enabled) begin
            error_sum_in = '0;
         end else begin
            mode_in = mode_sel;
            if (mode_sel == MODE_TRANSLATE) begin
               error_sum_in  = ki_active ? sum_sat : '0;
               last_error_in = err;
            end
         end
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TRANSLATE;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         ctrl_ff  <= ctrl_sel;
         err_ff   <= err;
         delta_ff <= err - last_error_ff;
         sum_ff   <= error_sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_err   = err_ff;
   assign out_delta = delta_ff;
   assign out_sum   = sum_ff;

   `HPM_ASSERT_NEXT(a_integ_clear, clock, reset, in_fire && !motors_enabled, error_sum_ff == '0)
   `HPM_ASSERT_IMPL(a_err_range, clock, reset, 1'b1, last_error_ff <= HALF_TURN && last_error_ff >= -HALF_TURN)
   `HPM_ASSERT_NEXT(a_spin_keeps, clock, reset, in_fire && motors_enabled && mode_sel != MODE_TRANSLATE, $stable(last_error_ff) && $stable(error_sum_ff))

endmodule

`default_nettype wire

@@ design/hpm_mult.sv @@
`default_nettype none

module hpm_mult #(
   parameter int INTEG_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  hpm_pkg::cfg_type                              cfg,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  hpm_pkg::ctrl_type                             in_ctrl,
   input  logic signed [hpm_pkg::ERR_W-1:0]              in_err,
   input  logic signed [hpm_pkg::ERR_W-1:0]              in_delta,
   input  logic signed [INTEG_WIDTH-1:0]                 in_sum,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output hpm_pkg::ctrl_type                             out_ctrl,
   output logic signed [hpm_pkg::GAIN_W+hpm_pkg::ERR_W-1:0] out_p,
   output logic signed [hpm_pkg::GAIN_W+INTEG_WIDTH-1:0]    out_i,
   output logic signed [hpm_pkg::GAIN_W+hpm_pkg::ERR_W-1:0] out_d
);
   import hpm_pkg::*;

   localparam int PD_W = GAIN_W + ERR_W;
   localparam int I_W  = GAIN_W + INTEG_WIDTH;

   logic                   in_fire;
   logic                   valid_ff, valid_in;
   ctrl_type               ctrl_ff;
   logic signed [PD_W-1:0] p_ff;
   logic signed [I_W-1:0]  i_ff;
   logic signed [PD_W-1:0] d_ff;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         ctrl_ff <= in_ctrl;
         p_ff    <= PD_W'(cfg.kp) * PD_W'(in_err);
         i_ff    <= I_W'(cfg.ki) * I_W'(in_sum);
         d_ff    <= PD_W'(cfg.kd) * PD_W'(in_delta);
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_p     = p_ff;
   assign out_i     = i_ff;
   assign out_d     = d_ff;

endmodule

`default_nettype wire

@@ design/hpm_acc.sv @@
`default_nettype none

module hpm_acc #(
   parameter int INTEG_WIDTH = 32
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  hpm_pkg::ctrl_type                                in_ctrl,
   input  logic signed [hpm_pkg::GAIN_W+hpm_pkg::ERR_W-1:0] in_p,
   input  logic signed [hpm_pkg::GAIN_W+INTEG_WIDTH-1:0]    in_i,
   input  logic signed [hpm_pkg::GAIN_W+hpm_pkg::ERR_W-1:0] in_d,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output hpm_pkg::ctrl_type                                out_ctrl,
   output logic signed [hpm_pkg::GAIN_W+INTEG_WIDTH+1:0]    out_acc
);
   import hpm_pkg::*;

   localparam int ACC_W = GAIN_W + INTEG_WIDTH + 2;

   logic                    in_fire;
   logic                    valid_ff, valid_in;
   ctrl_type                ctrl_ff;
   logic signed [ACC_W-1:0] acc_ff;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         ctrl_ff <= in_ctrl;
         acc_ff  <= ACC_W'(in_p) + ACC_W'(in_i) + ACC_W'(in_d);
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_acc   = acc_ff;

endmodule

`default_nettype wire

@@ design/hpm_mix.sv @@
`default_nettype none
`include "heading_pid_thruster_mixer_assert.svh"

module hpm_mix #(
   parameter int GAIN_FRAC_BITS = 8,
   parameter int INTEG_WIDTH    = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  hpm_pkg::ctrl_type                             in_ctrl,
   input  logic signed [hpm_pkg::GAIN_W+INTEG_WIDTH+1:0] in_acc,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [hpm_pkg::PULSE_W-1:0]                   out_a,
   output logic [hpm_pkg::PULSE_W-1:0]                   out_b,
   output logic [hpm_pkg::PULSE_W-1:0]                   out_c,
   output logic [hpm_pkg::PULSE_W-1:0]                   out_d,
   output logic signed [hpm_pkg::CORR_W-1:0]             out_corr
);
   import hpm_pkg::*;

   localparam int ACC_W = GAIN_W + INTEG_WIDTH + 2;
   localparam int SH    = GAIN_FRAC_BITS + 6;
   localparam int Q_W   = ACC_W - SH;
   localparam logic signed [ACC_W-1:0] ROUND = ACC_W'((1 << SH) - 1);

   logic                     in_fire;
   logic signed [ACC_W-1:0]  biased;
   logic signed [Q_W-1:0]    quot;
   logic signed [CORR_W-1:0] clamped;
   logic signed [CORR_W-1:0] corr;
   int                       base;

   logic                     valid_ff, valid_in;
   logic [PULSE_W-1:0]       a_ff, a_in;
   logic [PULSE_W-1:0]       b_ff, b_in;
   logic [PULSE_W-1:0]       c_ff, c_in;
   logic [PULSE_W-1:0]       d_ff, d_in;
   logic signed [CORR_W-1:0] corr_ff;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      // divide by 2^SH, truncating toward zero
      biased = in_acc + (in_acc[ACC_W-1] ? ROUND : '0);
      quot   = biased[ACC_W-1:SH];
      if (quot > Q_W'(OUT_LIMIT)) begin
         clamped = CORR_W'(OUT_LIMIT);
      end else if (quot < -Q_W'(OUT_LIMIT)) begin
         clamped = CORR_W'(-OUT_LIMIT);
      end else begin
         clamped = CORR_W'(quot);
      end
      corr = (in_ctrl.mix == MIX_PID) ? clamped : '0;

      a_in = PULSE_W'(NEUTRAL);
      b_in = PULSE_W'(NEUTRAL);
      c_in = PULSE_W'(NEUTRAL);
      d_in = PULSE_W'(NEUTRAL);
      base = NEUTRAL;
      case (in_ctrl.mix)
         MIX_SPIN_LEFT: begin
            a_in = PULSE_W'(SPIN_LOW);
            b_in = PULSE_W'(SPIN_HIGH);
            c_in = PULSE_W'(SPIN_LOW);
            d_in = PULSE_W'(SPIN_HIGH);
         end
         MIX_SPIN_RIGHT: begin
            a_in = PULSE_W'(SPIN_HIGH);
            b_in = PULSE_W'(SPIN_LOW);
            c_in = PULSE_W'(SPIN_HIGH);
            d_in = PULSE_W'(SPIN_LOW);
         end
         MIX_PID: begin
            case (in_ctrl.dir) inside
               DIR_FWD, DIR_RIGHT: base = BASE_HIGH;
               DIR_BACK, DIR_LEFT: base = BASE_LOW;
               default:            base = NEUTRAL;
            endcase
            if (in_ctrl.dir != DIR_LEFT && in_ctrl.dir != DIR_RIGHT) begin
               c_in = PULSE_W'(base - int'(corr));
               d_in = PULSE_W'(base + int'(corr));
            end
            if (in_ctrl.dir != DIR_FWD && in_ctrl.dir != DIR_BACK) begin
               a_in = PULSE_W'(base - int'(corr));
               b_in = PULSE_W'(base + int'(corr));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
         corr_ff <= corr;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_c     = c_ff;
   assign out_d     = d_ff;
   assign out_corr  = corr_ff;

   `HPM_ASSERT_IMPL(a_corr_range, clock, reset, valid_ff, corr_ff <= OUT_LIMIT && corr_ff >= -OUT_LIMIT)

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import hpm_pkg::*;

   localparam int     FRAC_BITS    = 8;
   localparam int     SUM_BITS     = 32;
   localparam longint SUM_MAX      = (longint'(1) <<< (SUM_BITS - 1)) - 1;
   localparam longint SUM_MIN      = -SUM_MAX - 1;
   localparam longint CORR_SCALE   = longint'(1) <<< (FRAC_BITS + 6);
   localparam longint KI_FLOOR     = longint'(1) <<< FRAC_BITS;
   localparam int     UNITY_GAIN   = 1 << FRAC_BITS;
   localparam int     DRAIN_CYCLES = 12;
   localparam longint TIMEOUT_NS   = 2_000_000;

   typedef struct packed {
      logic signed [YAW_W-1:0]   yaw;
      logic signed [STICK_W-1:0] sx;
      logic signed [STICK_W-1:0] sy;
      logic                      left;
      logic                      right;
      logic                      enabled;
   } tick_type;

   typedef struct packed {
      logic [PULSE_W-1:0]       a;
      logic [PULSE_W-1:0]       b;
      logic [PULSE_W-1:0]       c;
      logic [PULSE_W-1:0]       d;
      logic signed [CORR_W-1:0] corr;
   } thrust_cmd_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_TARGET;
   logic [CSR_DATA_W-1:0]       csr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [YAW_W-1:0]     req_yaw = '0;
   logic signed [STICK_W-1:0]   req_stick_x = '0;
   logic signed [STICK_W-1:0]   req_stick_y = '0;
   logic                        req_left_switch = 1'b0;
   logic                        req_right_switch = 1'b0;
   logic                        req_motors_enabled = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [PULSE_W-1:0]          rsp_thruster_a;
   logic [PULSE_W-1:0]          rsp_thruster_b;
   logic [PULSE_W-1:0]          rsp_thruster_c;
   logic [PULSE_W-1:0]          rsp_thruster_d;
   logic signed [CORR_W-1:0]    rsp_correction;

   // predicted controller state
   logic signed [YAW_W-1:0]     cfg_target = '0;
   logic signed [GAIN_W-1:0]    cfg_kp = '0;
   logic signed [GAIN_W-1:0]    cfg_ki = '0;
   logic signed [GAIN_W-1:0]    cfg_kd = '0;
   logic signed [ERR_W-1:0]     last_err = '0;
   logic signed [SUM_BITS-1:0]  err_sum = '0;
   mode_type                    drive = MODE_TRANSLATE;

   thrust_cmd_type              pending_thrust[$];
   thrust_cmd_type              got_cmd;
   thrust_cmd_type              want_cmd;
   int                          fail_count = 0;

   int                          req_gap_max = 0;
   int                          rsp_stall_max = 0;
   int                          hold_request = 0;
   int                          hold_left = 0;
   int                          run_left = 0;
   bit                          stalling = 1'b0;

   heading_pid_thruster_mixer #(
      .GAIN_FRAC_BITS(FRAC_BITS),
      .INTEG_WIDTH(SUM_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_yaw(req_yaw),
      .req_stick_x(req_stick_x),
      .req_stick_y(req_stick_y),
      .req_left_switch(req_left_switch),
      .req_right_switch(req_right_switch),
      .req_motors_enabled(req_motors_enabled),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_thruster_a(rsp_thruster_a),
      .rsp_thruster_b(rsp_thruster_b),
      .rsp_thruster_c(rsp_thruster_c),
      .rsp_thruster_d(rsp_thruster_d),
      .rsp_correction(rsp_correction)
   );

   always #10 clock = ~clock;

   function automatic thrust_cmd_type thrust_for_tick(tick_type t);
      thrust_cmd_type r;
      longint      err;
      longint      sum;
      longint      acc;
      longint      ki_mag;
      longint      corr;
      r.a = PULSE_W'(NEUTRAL);
      r.b = PULSE_W'(NEUTRAL);
      r.c = PULSE_W'(NEUTRAL);
      r.d = PULSE_W'(NEUTRAL);
      r.corr = '0;
      if (!t.enabled) begin
         err_sum = '0;
         return r;
      end
      if (!t.left && !t.right) drive = MODE_TRANSLATE;
      else if (t.left && !t.right) drive = MODE_SPIN_LEFT;
      else if (!t.left && t.right) drive = MODE_SPIN_RIGHT;
      case (drive)
         MODE_SPIN_LEFT: begin
            r.a = PULSE_W'(SPIN_LOW);
            r.b = PULSE_W'(SPIN_HIGH);
            r.c = PULSE_W'(SPIN_LOW);
            r.d = PULSE_W'(SPIN_HIGH);
         end
         MODE_SPIN_RIGHT: begin
            r.a = PULSE_W'(SPIN_HIGH);
            r.b = PULSE_W'(SPIN_LOW);
            r.c = PULSE_W'(SPIN_HIGH);
            r.d = PULSE_W'(SPIN_LOW);
         end
         default: begin
            err = longint'($signed(cfg_target)) - longint'($signed(t.yaw));
            if (err > HALF_TURN) err = err - FULL_TURN;
            else if (err < -HALF_TURN) err = err + FULL_TURN;
            ki_mag = longint'(cfg_ki);
            if (ki_mag < 0) ki_mag = -ki_mag;
            if (ki_mag * KI_SCALE > KI_FLOOR) begin
               sum = longint'(err_sum) + err;
               if (sum > SUM_MAX) sum = SUM_MAX;
               if (sum < SUM_MIN) sum = SUM_MIN;
               err_sum = SUM_BITS'(sum);
            end else begin
               err_sum = '0;
            end
            acc = longint'(cfg_kp) * err + longint'(cfg_ki) * longint'(err_sum)
                  + longint'(cfg_kd) * (err - longint'(last_err));
            last_err = ERR_W'(err);
            acc = acc / CORR_SCALE;
            if (acc > OUT_LIMIT) acc = OUT_LIMIT;
            if (acc < -OUT_LIMIT) acc = -OUT_LIMIT;
            corr = acc;
            r.corr = CORR_W'(corr);
            if (t.sy == STICK_POS) begin
               r.c = PULSE_W'(BASE_HIGH - corr);
               r.d = PULSE_W'(BASE_HIGH + corr);
            end else if (t.sy == STICK_NEG) begin
               r.c = PULSE_W'(BASE_LOW - corr);
               r.d = PULSE_W'(BASE_LOW + corr);
            end else if (t.sx == STICK_NEG) begin
               r.a = PULSE_W'(BASE_LOW - corr);
               r.b = PULSE_W'(BASE_LOW + corr);
            end else if (t.sx == STICK_POS) begin
               r.a = PULSE_W'(BASE_HIGH - corr);
               r.b = PULSE_W'(BASE_HIGH + corr);
            end else begin
               r.a = PULSE_W'(NEUTRAL - corr);
               r.b = PULSE_W'(NEUTRAL + corr);
               r.c = PULSE_W'(NEUTRAL - corr);
               r.d = PULSE_W'(NEUTRAL + corr);
            end
         end
      endcase
      return r;
   endfunction

   function automatic tick_type make_tick(int yaw, int sx, int sy, bit left, bit right, bit en);
      tick_type t;
      t.yaw = YAW_W'(yaw);
      t.sx = STICK_W'(sx);
      t.sy = STICK_W'(sy);
      t.left = left;
      t.right = right;
      t.enabled = en;
      return t;
   endfunction

   function automatic int random_stick();
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      if (pick < 3) v = STICK_FULL;
      else if (pick < 5) v = -STICK_FULL;
      else if (pick < 7) v = $urandom_range(0, 200) - 100;
      else if (pick < 9) v = $urandom_range(0, 1023) - 512;
      else v = ($urandom_range(0, 1) == 1) ? $urandom_range(495, 505) : -$urandom_range(495, 505);
      return v;
   endfunction

   function automatic tick_type random_tick();
      int pick;
      int yaw;
      int sw;
      pick = $urandom_range(0, 99);
      if (pick < 15) yaw = $urandom_range(0, 32767) - 16384;
      else if (pick < 45) yaw = $signed(cfg_target) + $urandom_range(0, 400) - 200;
      else yaw = $urandom_range(0, 2 * HALF_TURN) - HALF_TURN;
      sw = $urandom_range(0, 9);
      return make_tick(yaw, random_stick(), random_stick(), sw == 7 || sw == 9,
                       sw == 8 || sw == 9, $urandom_range(0, 99) < 88);
   endfunction

   function automatic int random_gain(bit integ);
      int pick;
      int v;
      pick = $urandom_range(0, 11);
      case (pick) inside
         0: v = -32768;
         1: v = 32767;
         2: v = 0;
         3, 4: v = $urandom_range(0, 65535) - 32768;
         default: v = $urandom_range(0, 1024) - 512;
      endcase
      if (integ && pick == 2) begin
         v = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 3)
                                         : -$urandom_range(2, 3);
      end
      return v;
   endfunction

   // sender
   task automatic send_tick(input tick_type t);
      @(negedge clock);
      req_valid <= 1'b1;
      req_yaw <= t.yaw;
      req_stick_x <= t.sx;
      req_stick_y <= t.sy;
      req_left_switch <= t.left;
      req_right_switch <= t.right;
      req_motors_enabled <= t.enabled;
      do @(posedge clock); while (!req_ready);
      pending_thrust.push_back(thrust_for_tick(t));
   endtask

   task automatic idle_req(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      idle_req(1);
      while (pending_thrust.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TARGET: cfg_target = data[YAW_W-1:0];
         CSR_PROP: cfg_kp = data;
         CSR_INTEG: cfg_ki = data;
         CSR_DERIV: cfg_kd = data;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_gains(input int target, input int kp, input int ki, input int kd);
      wait_drained();
      write_reg(CSR_TARGET, CSR_DATA_W'(target));
      write_reg(CSR_PROP, CSR_DATA_W'(kp));
      write_reg(CSR_INTEG, CSR_DATA_W'(ki));
      write_reg(CSR_DERIV, CSR_DATA_W'(kd));
   endtask

   // receiver: random ready/stall runs, plus a long hold when requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_max == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            stalling = !stalling;
            run_left = stalling ? $urandom_range(1, rsp_stall_max) : $urandom_range(1, 12);
         end
         run_left = run_left - 1;
         rsp_ready <= !stalling;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_cmd = '{rsp_thruster_a, rsp_thruster_b, rsp_thruster_c, rsp_thruster_d,
                     rsp_correction};
         if (pending_thrust.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
               $display("unexpected transfer: a=%0d b=%0d c=%0d d=%0d corr=%0d",
                        got_cmd.a, got_cmd.b, got_cmd.c, got_cmd.d, got_cmd.corr);
         end else begin
            want_cmd = pending_thrust.pop_front();
            if (got_cmd.a !== want_cmd.a || got_cmd.b !== want_cmd.b ||
                got_cmd.c !== want_cmd.c || got_cmd.d !== want_cmd.d ||
                got_cmd.corr !== want_cmd.corr) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $write("mismatch at %0t: exp a=%0d b=%0d c=%0d d=%0d corr=%0d, ",
                         $realtime, want_cmd.a, want_cmd.b, want_cmd.c, want_cmd.d,
                         want_cmd.corr);
                  $display("got a=%0d b=%0d c=%0d d=%0d corr=%0d",
                           got_cmd.a, got_cmd.b, got_cmd.c, got_cmd.d, got_cmd.corr);
               end
            end
         end
      end
   end

   task automatic apply_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   // correction = error in whole degrees at unity gain
   task automatic test_mix_directions();
      rsp_stall_max = 3;
      set_gains(0, UNITY_GAIN, 0, 0);
      send_tick(make_tick(640, 0, STICK_FULL, 0, 0, 1));
      send_tick(make_tick(-960, 0, -STICK_FULL, 0, 0, 1));
      send_tick(make_tick(320, -STICK_FULL, 0, 0, 0, 1));
      send_tick(make_tick(-320, STICK_FULL, 0, 0, 0, 1));
      send_tick(make_tick(1280, 12, -7, 0, 0, 1));
      send_tick(make_tick(-640, -STICK_FULL, STICK_FULL, 0, 0, 1));
   endtask

   task automatic test_spin_modes();
      send_tick(make_tick(640, 0, 0, 1, 0, 1));
      send_tick(make_tick(640, 0, 0, 0, 1, 1));
      send_tick(make_tick(640, 0, 0, 1, 1, 1));
      send_tick(make_tick(640, STICK_FULL, 0, 1, 1, 0));
      send_tick(make_tick(640, 0, 0, 1, 1, 1));
      send_tick(make_tick(640, 0, 0, 0, 0, 1));
      send_tick(make_tick(-640, 0, 0, 1, 1, 1));
   endtask

   task automatic test_heading_wrap();
      send_tick(make_tick(-HALF_TURN - 1, 0, 0, 0, 0, 1));
      send_tick(make_tick(HALF_TURN + 1, 0, 0, 0, 0, 1));
      send_tick(make_tick(-HALF_TURN, 0, 0, 0, 0, 1));
      send_tick(make_tick(-16384, 0, 0, 0, 0, 1));
      set_gains(HALF_TURN, UNITY_GAIN, 0, 0);
      send_tick(make_tick(-HALF_TURN, 0, 0, 0, 0, 1));
      set_gains(-HALF_TURN, UNITY_GAIN, 0, UNITY_GAIN);
      send_tick(make_tick(16383, 0, 0, 0, 0, 1));
   endtask

   // integral runs only when |Ki| is over 0.01
   task automatic test_integral_gate();
      set_gains(0, 0, 2, 0);
      send_tick(make_tick(-6400, 0, 0, 0, 0, 1));
      set_gains(0, 0, 3, 0);
      send_tick(make_tick(-6400, 0, 0, 0, 0, 1));
      send_tick(make_tick(-6400, 0, 0, 0, 0, 1));
      send_tick(make_tick(-6400, 0, 0, 0, 0, 0));
      send_tick(make_tick(-6400, 0, 0, 0, 0, 1));
      set_gains(0, 0, -2, 0);
      send_tick(make_tick(-6400, 0, 0, 0, 0, 1));
   endtask

   task automatic test_gain_extremes();
      set_gains(HALF_TURN, 32767, -32768, -32768);
      send_tick(make_tick(HALF_TURN - 3, STICK_FULL, 0, 0, 0, 1));
      send_tick(make_tick(HALF_TURN + 5, 0, -STICK_FULL, 0, 0, 1));
      set_gains(-HALF_TURN, -32768, 32767, 32767);
      send_tick(make_tick(HALF_TURN, 0, 0, 0, 0, 1));
   endtask

   // hold the receiver off long enough to fill the pipeline and stall req_ready
   task automatic test_backpressure();
      set_gains(0, 300, 40, -200);
      rsp_stall_max = 0;
      hold_request = 60;
      repeat (24) send_tick(random_tick());
      wait_drained();
   endtask

   task automatic test_random_phases();
      int burst_left;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_gains(HALF_TURN, 32767, -32768, -32768);
            1: set_gains(-HALF_TURN, -32768, 32767, 32767);
            2: set_gains($urandom_range(0, 65535), random_gain(0), random_gain(1),
                         random_gain(0));
            default: set_gains($urandom_range(0, 2 * HALF_TURN) - HALF_TURN,
                               random_gain(0), random_gain(1), random_gain(0));
         endcase
         req_gap_max = (phase == 3) ? 0 : $urandom_range(2, 6);
         rsp_stall_max = (phase == 3) ? 0 : $urandom_range(1, 8);
         burst_left = 0;
         repeat (60) begin
            if (burst_left == 0) begin
               idle_req($urandom_range(0, req_gap_max));
               burst_left = $urandom_range(1, 16);
            end
            send_tick(random_tick());
            burst_left = burst_left - 1;
         end
      end
   endtask

   // wind the integral up with the largest error, then back down to zero
   task automatic test_integral_windup();
      rsp_stall_max = 0;
      set_gains(HALF_TURN, 0, 3, 0);
      send_tick(make_tick(0, 0, 0, 0, 0, 0));
      repeat (20) send_tick(make_tick(0, 0, 0, 0, 0, 1));
      set_gains(-HALF_TURN, 0, 3, 0);
      repeat (20) send_tick(make_tick(0, 0, 0, 0, 0, 1));
   endtask

   initial begin
      apply_reset();
      test_mix_directions();
      test_spin_modes();
      test_heading_wrap();
      test_integral_gate();
      test_gain_extremes();
      test_backpressure();
      test_random_phases();
      test_integral_windup();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_thrust.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
